FILE: sv/ffpa_pkg.sv
`default_nettype none
package ffpa_pkg;
  localparam int unsigned KindW  = 1;
  localparam int unsigned StartW = 8;
  localparam int unsigned CountW = 9;
  localparam int unsigned StatW  = 3;

  typedef enum logic [StatW-1:0] {
    ST_OK         = 3'd0,
    ST_ZERO       = 3'd1,
    ST_EXHAUSTED  = 3'd2,
    ST_TABLE_FULL = 3'd3,
    ST_NO_MATCH   = 3'd4
  } status_t;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture request
    logic scan_clr;   // clear scan counters
    logic page_step;  // advance page scan
    logic rec_step;   // advance record scan
    logic mark_step;  // write one page of the run
    logic mark_init;  // load page cursor for marking
    logic commit;     // write record / update totals
    logic out_load;   // register result
    logic clear_step; // page map clearing sweep
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_free;
    logic zero;
    logic too_big;
    logic run_found;
    logic page_done;
    logic slot_found;
    logic match_found;
    logic rec_done;
    logic mark_done;
    logic clear_done;
  } dp_stat_t;
endpackage
`default_nettype wire

FILE: sv/ffpa_if.sv
`default_nettype none
interface ffpa_req_if #(parameter int OWNER_WIDTH = 16);
  logic                          valid;
  logic                          ready;
  logic [ffpa_pkg::KindW-1:0]    kind;
  logic [OWNER_WIDTH-1:0]        owner_id;
  logic [ffpa_pkg::StartW-1:0]   start_page;
  logic [ffpa_pkg::CountW-1:0]   num_pages;
  modport source (output valid, kind, owner_id, start_page, num_pages, input ready);
  modport sink   (input valid, kind, owner_id, start_page, num_pages, output ready);
endinterface

interface ffpa_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [ffpa_pkg::StatW-1:0]    status;
  logic [ffpa_pkg::StartW-1:0]   granted_page;
  logic [ffpa_pkg::CountW-1:0]   free_pages;
  logic [ffpa_pkg::CountW-1:0]   used_pages;
  modport source (output valid, status, granted_page, free_pages, used_pages, input ready);
  modport sink   (input valid, status, granted_page, free_pages, used_pages, output ready);
endinterface
`default_nettype wire

FILE: sv/first_fit_page_allocator.sv
`default_nettype none
// First-fit page allocator. After reset the page map is cleared by a sweep of
// all POOL_PAGES pages, during which no item is accepted. One item is
// processed at a time: after the accept state and a decode state, an allocate
// scans the page map one page per cycle until a run fits or the map ends,
// then the record table one entry per cycle for a free slot, then marks count
// pages one per cycle, commits and loads the result. A free scans the record
// table for a matching record and then returns count pages the same way. A
// zero count, or an allocate larger than the pool, goes straight to the result.
// The result is held in an output register; the next item is taken once that
// register is free or being emptied.
module first_fit_page_allocator #(
  parameter int POOL_PAGES  = 256,
  parameter int MAX_RECORDS = 64,
  parameter int OWNER_WIDTH = 16
) (
  input wire logic   clk,
  input wire logic   rst,
  ffpa_req_if.sink   req,
  ffpa_rsp_if.source rsp
);
  ffpa_pkg::dp_cmd_t  cmd;
  ffpa_pkg::dp_stat_t stat;

  ffpa_ctrl u_ctrl (
    .clk(clk), .rst(rst), .req_valid(req.valid),
    .rsp_busy(rsp.valid && !rsp.ready), .stat(stat), .cmd(cmd)
  );

  ffpa_datapath #(
    .POOL_PAGES(POOL_PAGES), .MAX_RECORDS(MAX_RECORDS), .OWNER_WIDTH(OWNER_WIDTH)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat), .req(req), .rsp(rsp)
  );
endmodule
`default_nettype wire

FILE: sv/ffpa_ram.sv
`default_nettype none
module ffpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: sv/ffpa_datapath.sv
`default_nettype none
module ffpa_datapath #(
  parameter int POOL_PAGES  = 256,
  parameter int MAX_RECORDS = 64,
  parameter int OWNER_WIDTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ffpa_pkg::dp_cmd_t  cmd,
  output ffpa_pkg::dp_stat_t      stat,
  ffpa_req_if.sink                req,
  ffpa_rsp_if.source              rsp
);
  localparam int PW = $clog2(POOL_PAGES);
  localparam int RW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int CW = ffpa_pkg::CountW;
  localparam int SW = ffpa_pkg::StartW;
  localparam int RECW = OWNER_WIDTH + SW + CW;
  localparam logic [PW:0] PoolLast = (PW+1)'(POOL_PAGES - 1);

  // request registers
  logic                   kind;
  logic [OWNER_WIDTH-1:0] owner;
  logic [SW-1:0]          spage;
  logic [CW-1:0]          count;

  // page map memory: bit per page
  logic [PW:0]    page_idx;     // scan cursor, one extra bit to hold the end
  logic [CW:0]    run;
  logic [PW-1:0]  run_start;
  logic           run_found;
  logic [PW:0]    mark_idx;
  logic [CW-1:0]  mark_left;
  logic [PW:0]    clr_idx;
  logic           clear_done;
  logic           pm_we;
  logic [PW-1:0]  pm_waddr;
  logic           pm_wdata;
  logic           pm_rdata;
  logic           pm_rd_ok;     // read data belongs to previous page_idx
  logic [PW:0]    pm_rd_idx;

  // record table
  logic [MAX_RECORDS-1:0] rec_valid;
  logic [RW:0]            rec_idx;
  logic [RW-1:0]          slot;
  logic                   slot_found;
  logic [RW-1:0]          match;
  logic                   match_found;
  logic                   rec_rd_ok;
  logic [RW-1:0]          rec_rd_idx;
  logic [RECW-1:0]        rec_rdata;
  logic [CW-1:0]          used;
  logic                   rsp_valid;
  logic [ffpa_pkg::StatW-1:0] rsp_status;
  logic [SW-1:0]          rsp_granted;
  logic [CW-1:0]          rsp_free;
  logic [CW-1:0]          rsp_used;

  assign req.ready = cmd.load;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind  <= req.kind;
      owner <= req.owner_id;
      spage <= req.start_page;
      count <= req.num_pages;
    end
  end

  // page map write mux: clearing sweep or marking the run
  always_comb begin
    pm_we    = 1'b0;
    pm_waddr = clr_idx[PW-1:0];
    pm_wdata = 1'b1;
    if (cmd.clear_step) begin
      pm_we = 1'b1;
    end else if (cmd.mark_step && mark_left != '0) begin
      pm_we    = (mark_idx <= PoolLast);
      pm_waddr = mark_idx[PW-1:0];
      pm_wdata = kind;  // free sets pages, allocate clears them
    end
  end

  ffpa_ram #(.WIDTH(1), .DEPTH(POOL_PAGES)) u_pmap (
    .clk(clk), .we(pm_we), .waddr(pm_waddr), .wdata(pm_wdata),
    .raddr(page_idx[PW-1:0]), .rdata(pm_rdata)
  );

  ffpa_ram #(.WIDTH(RECW), .DEPTH(1 << RW)) u_rec (
    .clk(clk), .we(cmd.commit && kind == ffpa_pkg::KIND_ALLOC),
    .waddr(slot), .wdata({owner, SW'(run_start), count}),
    .raddr(rec_idx[RW-1:0]), .rdata(rec_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx    <= '0;
      clear_done <= 1'b0;
    end else if (cmd.clear_step) begin
      clr_idx <= clr_idx + 1'b1;
      if (clr_idx == PoolLast) clear_done <= 1'b1;
    end
  end

  // first-fit page scan, one page per cycle, with a registered page map read
  always_ff @(posedge clk) begin
    if (rst) begin
      pm_rd_ok <= 1'b0;
    end else if (cmd.scan_clr) begin
      page_idx  <= '0;
      pm_rd_ok  <= 1'b0;
      run       <= '0;
      run_found <= 1'b0;
      rec_idx   <= '0;
      rec_rd_ok <= 1'b0;
      slot_found  <= 1'b0;
      match_found <= 1'b0;
    end else begin
      if (cmd.page_step) begin
        pm_rd_ok  <= (page_idx <= PoolLast);
        pm_rd_idx <= page_idx;
        if (page_idx <= PoolLast) page_idx <= page_idx + 1'b1;
        if (pm_rd_ok && !run_found) begin
          if (pm_rdata) begin
            run <= run + 1'b1;
            if (run + 1'b1 >= {1'b0, count}) begin
              run_found <= 1'b1;
              run_start <= PW'(pm_rd_idx + 1'b1 - (PW+1)'(count));
            end
          end else begin
            run <= '0;
          end
        end
      end
      if (cmd.rec_step) begin
        rec_rd_ok  <= (rec_idx < (RW+1)'(MAX_RECORDS));
        rec_rd_idx <= rec_idx[RW-1:0];
        if (rec_idx < (RW+1)'(MAX_RECORDS)) rec_idx <= rec_idx + 1'b1;
        if (!slot_found && rec_idx < (RW+1)'(MAX_RECORDS) && !rec_valid[rec_idx[RW-1:0]]) begin
          slot_found <= 1'b1;
          slot       <= rec_idx[RW-1:0];
        end
        if (rec_rd_ok && !match_found && rec_valid[rec_rd_idx] &&
            rec_rdata == {owner, spage, count}) begin
          match_found <= 1'b1;
          match       <= rec_rd_idx;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mark_init) begin
      mark_idx  <= kind ? (PW+1)'(spage) : {1'b0, run_start};
      mark_left <= count;
    end else if (cmd.mark_step && mark_left != '0) begin
      mark_idx  <= mark_idx + 1'b1;
      mark_left <= mark_left - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= '0;
      used      <= '0;
    end else if (cmd.commit) begin
      if (kind == ffpa_pkg::KIND_ALLOC) begin
        rec_valid[slot] <= 1'b1;
        used <= used + count;
      end else begin
        rec_valid[match] <= 1'b0;
        used <= (count <= used) ? used - count : '0;
      end
    end
  end

  always_comb begin
    stat.is_free     = (kind == ffpa_pkg::KIND_FREE);
    stat.zero        = (count == '0);
    stat.too_big     = (count > CW'(POOL_PAGES));
    stat.run_found   = run_found;
    stat.page_done   = !pm_rd_ok && (page_idx > PoolLast);
    stat.slot_found  = slot_found;
    stat.match_found = match_found;
    stat.rec_done    = !rec_rd_ok && (rec_idx >= (RW+1)'(MAX_RECORDS));
    stat.mark_done   = (mark_left == '0);
    stat.clear_done  = clear_done;
  end

  // result register; status chosen from scan outcome
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp_granted <= '0;
      if (count == '0) begin
        rsp_status <= ffpa_pkg::ST_ZERO;
      end else if (kind == ffpa_pkg::KIND_FREE) begin
        rsp_status <= match_found ? ffpa_pkg::ST_OK : ffpa_pkg::ST_NO_MATCH;
      end else if (!run_found || count > CW'(POOL_PAGES)) begin
        rsp_status <= ffpa_pkg::ST_EXHAUSTED;
      end else if (!slot_found) begin
        rsp_status <= ffpa_pkg::ST_TABLE_FULL;
      end else begin
        rsp_status  <= ffpa_pkg::ST_OK;
        rsp_granted <= SW'(run_start);
      end
      rsp_used <= used;
      rsp_free <= CW'(POOL_PAGES) - used;
    end
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.status       = rsp_status;
  assign rsp.granted_page = rsp_granted;
  assign rsp.free_pages   = rsp_free;
  assign rsp.used_pages   = rsp_used;

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= CW'(POOL_PAGES)) else $error("used pages above pool size");
  a_commit_alloc_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && !kind |-> slot_found && run_found) else $error("alloc commit without slot");
  a_commit_free_match: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && kind |-> match_found) else $error("free commit without match");
endmodule
`default_nettype wire

FILE: sv/ffpa_ctrl.sv
`default_nettype none
module ffpa_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  input  wire logic               rsp_busy,
  input  wire ffpa_pkg::dp_stat_t stat,
  output ffpa_pkg::dp_cmd_t       cmd
);
  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_DECIDE = 8'b0000_0100,
    S_PSCAN  = 8'b0000_1000,
    S_RSCAN  = 8'b0001_0000,
    S_MARK   = 8'b0010_0000,
    S_COMMIT = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_done) begin
          cmd.clear_step = 1'b0;
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        cmd.load = !rsp_busy;
        if (req_valid && !rsp_busy) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.scan_clr = 1'b1;
        if (stat.zero) state_next = S_DONE;
        else if (stat.is_free) state_next = S_RSCAN;
        else if (stat.too_big) state_next = S_DONE;
        else state_next = S_PSCAN;
      end
      S_PSCAN: begin
        cmd.page_step = 1'b1;
        if (stat.run_found) begin
          cmd.page_step = 1'b0;
          state_next = S_RSCAN;
        end else if (stat.page_done) begin
          state_next = S_DONE;
        end
      end
      S_RSCAN: begin
        cmd.rec_step = 1'b1;
        if (!stat.is_free && stat.slot_found) begin
          cmd.rec_step = 1'b0;
          cmd.mark_init = 1'b1;
          state_next = S_MARK;
        end else if (stat.is_free && stat.match_found) begin
          cmd.rec_step = 1'b0;
          cmd.mark_init = 1'b1;
          state_next = S_MARK;
        end else if (stat.rec_done) begin
          state_next = S_DONE;
        end
      end
      S_MARK: begin
        cmd.mark_step = 1'b1;
        if (stat.mark_done) state_next = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        cmd.out_load = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> state == S_IDLE) else $error("load outside idle");
  a_commit_then_done: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> state == S_DONE) else $error("commit not followed by result");
  a_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.scan_clr, cmd.page_step, cmd.rec_step, cmd.mark_init,
              cmd.mark_step, cmd.commit, cmd.out_load, cmd.clear_step}))
    else $error("overlapping commands");
endmodule
`default_nettype wire

FILE: bench/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Pages = 256;
  localparam int Records = 64;
  localparam longint CycleLimit = 4000000;

  typedef struct packed {
    logic       kind;
    logic [15:0] owner;
    logic [7:0]  spage;
    logic [8:0]  count;
  } request_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] granted;
    logic [8:0] free_n;
    logic [8:0] used_n;
  } grant_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ffpa_req_if #(.OWNER_WIDTH(16)) req ();
  ffpa_rsp_if rsp ();

  first_fit_page_allocator dut (
    .clk(clk),
    .rst(rst),
    .req(req.sink),
    .rsp(rsp.source)
  );

  // predictor state
  bit          free_map[Pages];
  bit          rec_live[Records];
  logic [15:0] rec_owner[Records];
  logic [7:0]  rec_start[Records];
  logic [8:0]  rec_len[Records];
  int          used_total;

  request_t pending_reqs[$];
  grant_t   expected_grants[$];
  int       errors = 0;
  int       send_idle_pct = 12;
  int       recv_idle_pct = 60;
  longint   cycles = 0;

  function automatic grant_t predict_grant(request_t r);
    grant_t g;
    int run;
    int found;
    int slot;
    g = '0;
    found = -1;
    slot = -1;
    if (r.count == 0) begin
      g.status = ffpa_pkg::ST_ZERO;
    end else if (r.kind == ffpa_pkg::KIND_ALLOC) begin
      run = 0;
      if (r.count <= Pages) begin
        for (int i = 0; i < Pages; i++) begin
          if (free_map[i]) begin
            run++;
            if (run >= r.count) begin
              found = i + 1 - r.count;
              break;
            end
          end else begin
            run = 0;
          end
        end
      end
      for (int i = 0; i < Records; i++) begin
        if (!rec_live[i]) begin
          slot = i;
          break;
        end
      end
      if (found < 0) begin
        g.status = ffpa_pkg::ST_EXHAUSTED;
      end else if (slot < 0) begin
        g.status = ffpa_pkg::ST_TABLE_FULL;
      end else begin
        for (int i = 0; i < r.count; i++) free_map[found + i] = 1'b0;
        rec_live[slot] = 1'b1;
        rec_owner[slot] = r.owner;
        rec_start[slot] = found[7:0];
        rec_len[slot] = r.count;
        used_total += r.count;
        g.granted = found[7:0];
        g.status = ffpa_pkg::ST_OK;
      end
    end else begin
      g.status = ffpa_pkg::ST_NO_MATCH;
      for (int i = 0; i < Records; i++) begin
        if (rec_live[i] && rec_owner[i] == r.owner && rec_start[i] == r.spage &&
            rec_len[i] == r.count) begin
          for (int p = 0; p < r.count; p++)
            if (r.spage + p < Pages) free_map[r.spage + p] = 1'b1;
          rec_live[i] = 1'b0;
          used_total -= (r.count <= used_total) ? r.count : used_total;
          g.status = ffpa_pkg::ST_OK;
          break;
        end
      end
    end
    g.free_n = 9'(Pages - used_total);
    g.used_n = 9'(used_total);
    return g;
  endfunction

  // pick a live record (or -1)
  function automatic int any_live_record();
    int picks[$];
    for (int i = 0; i < Records; i++) if (rec_live[i]) picks.push_back(i);
    if (picks.size() == 0) return -1;
    return picks[$urandom_range(picks.size() - 1)];
  endfunction

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Timeout at %0t", $time);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // driver
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
      req.kind <= '0;
      req.owner_id <= '0;
      req.start_page <= '0;
      req.num_pages <= '0;
    end else if (!req.valid || req.ready) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        request_t r;
        r = pending_reqs.pop_front();
        expected_grants.push_back(predict_grant(r));
        req.valid <= 1'b1;
        req.kind <= r.kind;
        req.owner_id <= r.owner;
        req.start_page <= r.spage;
        req.num_pages <= r.count;
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_grants.size() == 0) begin
          $display("%0t unexpected result status=%0d", $time, rsp.status);
          errors++;
        end else begin
          grant_t e;
          grant_t a;
          e = expected_grants.pop_front();
          a = '{rsp.status, rsp.granted_page, rsp.free_pages, rsp.used_pages};
          if (a.status !== e.status) begin
            $display("%0t status exp %0d got %0d", $time, e.status, a.status);
            errors++;
          end
          if (a.granted !== e.granted) begin
            $display("%0t granted_page exp %0d got %0d", $time, e.granted, a.granted);
            errors++;
          end
          if (a.free_n !== e.free_n) begin
            $display("%0t free_pages exp %0d got %0d", $time, e.free_n, a.free_n);
            errors++;
          end
          if (a.used_n !== e.used_n) begin
            $display("%0t used_pages exp %0d got %0d", $time, e.used_n, a.used_n);
            errors++;
          end
        end
      end
      rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic add(logic k, logic [15:0] o, logic [7:0] s, logic [8:0] c);
    request_t r;
    r = '{k, o, s, c};
    pending_reqs.push_back(r);
  endtask

  task automatic wait_sent();
    while (pending_reqs.size() != 0) @(posedge clk);
  endtask

  task automatic drain();
    while (pending_reqs.size() != 0 || expected_grants.size() != 0) @(posedge clk);
  endtask

  // Frees are built against the predictor once everything before them is sent.
  task automatic run_phase(int n);
    request_t r;
    int rec;
    for (int i = 0; i < n; i++) begin
      wait_sent();
      if ($urandom_range(99) < 55) begin
        rec = any_live_record();
        if (rec >= 0) begin
          r = '{ffpa_pkg::KIND_FREE, rec_owner[rec], rec_start[rec], rec_len[rec]};
          if ($urandom_range(9) == 0) r.owner ^= 16'(1 << $urandom_range(15));
        end else begin
          r = '{ffpa_pkg::KIND_ALLOC, 16'($urandom), 8'($urandom),
                9'($urandom_range(12, 1))};
        end
      end else begin
        case ($urandom_range(9))
          0: r = '{1'($urandom), 16'($urandom), 8'($urandom), 9'd0};
          1: r = '{ffpa_pkg::KIND_FREE, 16'($urandom), 8'($urandom), 9'($urandom)};
          2: r = '{ffpa_pkg::KIND_ALLOC, 16'($urandom), 8'($urandom), 9'($urandom)};
          3: r = '{ffpa_pkg::KIND_ALLOC, 16'($urandom), 8'($urandom),
                   9'($urandom_range(256, 1))};
          default: r = '{ffpa_pkg::KIND_ALLOC, 16'($urandom), 8'($urandom),
                         9'($urandom_range(10, 1))};
        endcase
      end
      pending_reqs.push_back(r);
    end
    drain();
  endtask

  initial begin
    int rec;
    for (int i = 0; i < Pages; i++) free_map[i] = 1'b1;
    for (int i = 0; i < Records; i++) rec_live[i] = 1'b0;
    used_total = 0;

    // directed: zero counts, oversize, whole pool, no-match, free, coalesce
    add(ffpa_pkg::KIND_ALLOC, 16'h0000, 8'h00, 9'd0);
    add(ffpa_pkg::KIND_FREE, 16'hffff, 8'hff, 9'd0);
    add(ffpa_pkg::KIND_ALLOC, 16'hffff, 8'hff, 9'd511);
    add(ffpa_pkg::KIND_ALLOC, 16'h1234, 8'h00, 9'd257);
    add(ffpa_pkg::KIND_ALLOC, 16'hffff, 8'h00, 9'd256);
    add(ffpa_pkg::KIND_ALLOC, 16'h0001, 8'h00, 9'd1);
    add(ffpa_pkg::KIND_FREE, 16'hfffe, 8'h00, 9'd256);
    add(ffpa_pkg::KIND_FREE, 16'hffff, 8'h01, 9'd256);
    add(ffpa_pkg::KIND_FREE, 16'hffff, 8'h00, 9'd256);
    add(ffpa_pkg::KIND_ALLOC, 16'h0001, 8'h00, 9'd100);
    add(ffpa_pkg::KIND_ALLOC, 16'h0002, 8'h00, 9'd100);
    add(ffpa_pkg::KIND_ALLOC, 16'h0003, 8'h00, 9'd56);
    add(ffpa_pkg::KIND_FREE, 16'h0001, 8'h00, 9'd100);
    add(ffpa_pkg::KIND_FREE, 16'h0002, 8'd100, 9'd100);
    add(ffpa_pkg::KIND_ALLOC, 16'h0004, 8'h00, 9'd200);
    add(ffpa_pkg::KIND_FREE, 16'h0004, 8'h00, 9'd200);
    add(ffpa_pkg::KIND_FREE, 16'h0003, 8'd200, 9'd56);
    add(ffpa_pkg::KIND_FREE, 16'h0003, 8'd200, 9'd56);
    drain();
    // fill the record table with single pages, then hit the full table
    for (int i = 0; i < Records + 2; i++) add(ffpa_pkg::KIND_ALLOC, 16'(i), 8'h00, 9'd1);
    add(ffpa_pkg::KIND_ALLOC, 16'h5555, 8'h00, 9'd300);
    drain();
    // free everything that is still live
    forever begin
      rec = any_live_record();
      if (rec < 0) break;
      add(ffpa_pkg::KIND_FREE, rec_owner[rec], rec_start[rec], rec_len[rec]);
      wait_sent();
    end
    drain();

    run_phase(500);
    send_idle_pct = 60;
    recv_idle_pct = 12;
    run_phase(500);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(500);
    repeat (1000) @(posedge clk);
    if (errors == 0 && expected_grants.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
